// ----- design/idq_pkg.sv -----
// Package for the input-restricted deque: depth, widths, operation and status codes,
// and the command bundle that the controller sends to the datapath.
// No dependencies.
package idq_pkg;

  localparam int unsigned DEPTH = 8;
  localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned DATA_W = 32;

  typedef enum logic [1:0] {
    OP_PUSH_REAR = 2'd0,
    OP_POP_FRONT = 2'd1,
    OP_POP_REAR  = 2'd2,
    OP_NOP       = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef struct packed {
    logic load;
    logic exec;
  } cmd_t;

  function automatic logic [IDX_W-1:0] ring_next(input logic [IDX_W-1:0] i);
    return (i == IDX_W'(DEPTH - 1)) ? '0 : i + IDX_W'(1);
  endfunction

  function automatic logic [IDX_W-1:0] ring_prev(input logic [IDX_W-1:0] i);
    return (i == '0) ? IDX_W'(DEPTH - 1) : i - IDX_W'(1);
  endfunction

endpackage

// ----- design/input_restricted_deque.sv -----
// Top level of the input-restricted deque: controller plus datapath.
// Depends on idq_pkg, idq_ctrl and idq_dpath.
//
//   channel  | handshake            | payload
//   ---------+----------------------+-----------------------------------------------
//   command  | start in, busy out   | operation_i, value_in_i
//   result   | done_o strobe out    | value_out_o, status_o, now_empty_o, now_full_o
//
// Each item passes through transfer, execute (one memory write or one
// registered memory read plus index update), then a single cycle with done_o high.
// busy is high from the cycle after the transfer until done_o drops.
// Reset empties the deque; slot contents are not cleared.
// The receiver cannot stall: each result shows for exactly one cycle.
module input_restricted_deque (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start,
  output logic                              busy,
  input  logic [1:0]                        operation_i,
  input  logic signed [idq_pkg::DATA_W-1:0] value_in_i,
  output logic                              done_o,
  output logic signed [idq_pkg::DATA_W-1:0] value_out_o,
  output logic [1:0]                        status_o,
  output logic                              now_empty_o,
  output logic                              now_full_o
);

  idq_pkg::cmd_t cmd;

  idq_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .done_o (done_o),
    .cmd_o  (cmd)
  );

  idq_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .operation_i (operation_i),
    .value_in_i  (value_in_i),
    .value_out_o (value_out_o),
    .status_o    (status_o),
    .now_empty_o (now_empty_o),
    .now_full_o  (now_full_o)
  );

endmodule

// ----- design/idq_ctrl.sv -----
// Controller state machine for the input-restricted deque.
// Depends on idq_pkg for the command bundle.
module idq_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  output logic              done_o,
  output idq_pkg::cmd_t     cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EXEC = 3'b010,
    S_DONE = 3'b100
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (start) state_d = S_EXEC;
      S_EXEC: state_d = S_DONE;
      S_DONE: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy        = (state_q != S_IDLE);
  assign done_o      = (state_q == S_DONE);
  assign cmd_o.load  = (state_q == S_IDLE) && start;
  assign cmd_o.exec  = (state_q == S_EXEC);

endmodule

// ----- design/idq_dpath.sv -----
// Datapath for the input-restricted deque: slot memory, ring indices, occupancy, result registers.
// Depends on idq_pkg for widths, codes and ring helpers.
module idq_dpath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  idq_pkg::cmd_t                 cmd_i,
  input  logic [1:0]                    operation_i,
  input  logic signed [idq_pkg::DATA_W-1:0] value_in_i,
  output logic signed [idq_pkg::DATA_W-1:0] value_out_o,
  output logic [1:0]                    status_o,
  output logic                          now_empty_o,
  output logic                          now_full_o
);

  logic [idq_pkg::DATA_W-1:0] mem_q [idq_pkg::DEPTH];

  idq_pkg::op_e               op_q;
  logic [idq_pkg::DATA_W-1:0] val_q;
  logic [idq_pkg::IDX_W-1:0]  front_q, front_d;
  logic [idq_pkg::IDX_W-1:0]  rear_q, rear_d;
  logic [idq_pkg::CNT_W-1:0]  occ_q, occ_d;
  idq_pkg::status_e           status_q, status_d;
  logic                       take_q, take_d;
  logic [idq_pkg::DATA_W-1:0] rd_data_q;

  logic                       wr_en;
  logic [idq_pkg::IDX_W-1:0]  wr_addr;
  logic [idq_pkg::IDX_W-1:0]  rd_addr;
  logic                       is_empty, is_full, is_last;

  assign is_empty = (occ_q == '0);
  assign is_full  = (occ_q == idq_pkg::CNT_W'(idq_pkg::DEPTH));
  assign is_last  = (occ_q == idq_pkg::CNT_W'(1));

  always_comb begin
    front_d  = front_q;
    rear_d   = rear_q;
    occ_d    = occ_q;
    status_d = idq_pkg::ST_DONE;
    take_d   = 1'b0;
    wr_en    = 1'b0;
    wr_addr  = is_empty ? '0 : idq_pkg::ring_next(rear_q);
    rd_addr  = (op_q == idq_pkg::OP_POP_FRONT) ? front_q : rear_q;
    unique case (op_q)
      idq_pkg::OP_PUSH_REAR: begin
        if (is_full) begin
          status_d = idq_pkg::ST_FULL;
        end else begin
          wr_en   = 1'b1;
          rear_d  = wr_addr;
          occ_d   = occ_q + idq_pkg::CNT_W'(1);
          if (is_empty) front_d = '0;
        end
      end
      idq_pkg::OP_POP_FRONT, idq_pkg::OP_POP_REAR: begin
        if (is_empty) begin
          status_d = idq_pkg::ST_EMPTY;
        end else begin
          take_d = 1'b1;
          occ_d  = occ_q - idq_pkg::CNT_W'(1);
          if (is_last) begin
            front_d = '0;
            rear_d  = '0;
          end else if (op_q == idq_pkg::OP_POP_FRONT) begin
            front_d = idq_pkg::ring_next(front_q);
          end else begin
            rear_d = idq_pkg::ring_prev(rear_q);
          end
        end
      end
      idq_pkg::OP_NOP: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec && wr_en) begin
      mem_q[wr_addr] <= val_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      rd_data_q <= mem_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q  <= idq_pkg::op_e'(operation_i);
      val_q <= value_in_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q  <= '0;
      rear_q   <= '0;
      occ_q    <= '0;
      status_q <= idq_pkg::ST_DONE;
      take_q   <= 1'b0;
    end else if (cmd_i.exec) begin
      front_q  <= front_d;
      rear_q   <= rear_d;
      occ_q    <= occ_d;
      status_q <= status_d;
      take_q   <= take_d;
    end
  end

  assign value_out_o = take_q ? $signed(rd_data_q) : '0;
  assign status_o    = status_q;
  assign now_empty_o = is_empty;
  assign now_full_o  = is_full;

endmodule

// ----- design/idq_checker.sv -----
// Port-level checker for the input-restricted deque, bound to the top level.
// Depends on idq_pkg for status codes and input_restricted_deque for the bind.
module idq_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              start,
  input logic                              busy,
  input logic                              done_o,
  input logic signed [idq_pkg::DATA_W-1:0] value_out_o,
  input logic [1:0]                        status_o,
  input logic                              now_empty_o,
  input logic                              now_full_o
);

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (busy && !done_o))
    else $error("busy not raised after transfer");

  a_result_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##2 done_o)
    else $error("result not delivered two cycles after transfer");

  a_done_in_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (busy && $past(busy)))
    else $error("result strobe outside busy window");

  a_flags_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !(now_empty_o && now_full_o))
    else $error("deque reported empty and full");

  a_refused_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (status_o == idq_pkg::ST_FULL || status_o == idq_pkg::ST_EMPTY))
      |-> (value_out_o == '0))
    else $error("refused operation returned data");

endmodule

bind input_restricted_deque idq_checker u_idq_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start       (start),
  .busy        (busy),
  .done_o      (done_o),
  .value_out_o (value_out_o),
  .status_o    (status_o),
  .now_empty_o (now_empty_o),
  .now_full_o  (now_full_o)
);

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for input_restricted_deque: directed corner cases, then random
// push/pop traffic, all checked against a ring-buffer predictor kept in step with each transfer.
// Depends on idq_pkg and the input_restricted_deque RTL.
module testbench;

  localparam int unsigned STALL_LIMIT = 500;
  localparam int unsigned MAX_SHOWN   = 10;

  typedef struct {
    logic [idq_pkg::DATA_W-1:0] value;
    idq_pkg::status_e           status;
    logic                       empty;
    logic                       full;
  } deque_result_t;

  logic                              clk_i = 1'b0;
  logic                              rst_ni;
  logic                              start;
  logic                              busy;
  logic [1:0]                        operation_i;
  logic signed [idq_pkg::DATA_W-1:0] value_in_i;
  logic                              done_o;
  logic signed [idq_pkg::DATA_W-1:0] value_out_o;
  logic [1:0]                        status_o;
  logic                              now_empty_o;
  logic                              now_full_o;

  logic [idq_pkg::DATA_W-1:0] slot_model [idq_pkg::DEPTH];
  int unsigned                head_idx;
  int unsigned                tail_idx;
  int unsigned                fill_count;

  deque_result_t pending_results[$];
  int unsigned   mismatches;
  int unsigned   stall_cycles;

  input_restricted_deque dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .operation_i(operation_i),
    .value_in_i (value_in_i),
    .done_o     (done_o),
    .value_out_o(value_out_o),
    .status_o   (status_o),
    .now_empty_o(now_empty_o),
    .now_full_o (now_full_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic deque_result_t deque_step(input idq_pkg::op_e op,
                                               input logic [idq_pkg::DATA_W-1:0] val);
    deque_result_t res;
    res.value  = '0;
    res.status = idq_pkg::ST_DONE;
    case (op)
      idq_pkg::OP_PUSH_REAR: begin
        if (fill_count >= idq_pkg::DEPTH) begin
          res.status = idq_pkg::ST_FULL;
        end else begin
          if (fill_count == 0) begin
            head_idx = 0;
            tail_idx = 0;
          end else begin
            tail_idx = (tail_idx == idq_pkg::DEPTH - 1) ? 0 : tail_idx + 1;
          end
          slot_model[tail_idx] = val;
          fill_count++;
        end
      end
      idq_pkg::OP_POP_FRONT, idq_pkg::OP_POP_REAR: begin
        if (fill_count == 0) begin
          res.status = idq_pkg::ST_EMPTY;
        end else if (op == idq_pkg::OP_POP_FRONT) begin
          res.value = slot_model[head_idx];
          if (fill_count == 1) begin
            head_idx = 0;
            tail_idx = 0;
            fill_count = 0;
          end else begin
            head_idx = (head_idx == idq_pkg::DEPTH - 1) ? 0 : head_idx + 1;
            fill_count--;
          end
        end else begin
          res.value = slot_model[tail_idx];
          if (fill_count == 1) begin
            head_idx = 0;
            tail_idx = 0;
            fill_count = 0;
          end else begin
            tail_idx = (tail_idx == 0) ? idq_pkg::DEPTH - 1 : tail_idx - 1;
            fill_count--;
          end
        end
      end
      default: begin
      end
    endcase
    res.empty = (fill_count == 0);
    res.full  = (fill_count >= idq_pkg::DEPTH);
    return res;
  endfunction

  // Predict on every command transfer.
  always @(posedge clk_i) begin
    if (rst_ni && start && !busy) begin
      pending_results.push_back(deque_step(idq_pkg::op_e'(operation_i), value_in_i));
    end
  end

  always @(posedge clk_i) begin
    deque_result_t exp_res;
    if (rst_ni && done_o) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_SHOWN) begin
          $display("ERROR: unexpected result value=%h status=%0d empty=%b full=%b",
                   value_out_o, status_o, now_empty_o, now_full_o);
        end
      end else begin
        exp_res = pending_results.pop_front();
        if (value_out_o !== exp_res.value || status_o !== exp_res.status ||
            now_empty_o !== exp_res.empty || now_full_o !== exp_res.full) begin
          mismatches++;
          if (mismatches <= MAX_SHOWN) begin
            $display({"ERROR: expected value=%h status=%0d empty=%b full=%b, ",
                      "got value=%h status=%0d empty=%b full=%b"},
                     exp_res.value, exp_res.status, exp_res.empty, exp_res.full,
                     value_out_o, status_o, now_empty_o, now_full_o);
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || done_o) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("ERROR: no transfer for %0d cycles", STALL_LIMIT);
      $display("*** FAILED ***");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic send_item(input idq_pkg::op_e op, input logic [idq_pkg::DATA_W-1:0] val);
    start       <= 1'b1;
    operation_i <= op;
    value_in_i  <= val;
    do @(posedge clk_i); while (busy);
  endtask

  task automatic idle_for(input int unsigned n);
    start <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    do @(negedge clk_i); while (pending_results.size() != 0);
    @(posedge clk_i);
  endtask

  function automatic logic [idq_pkg::DATA_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0000_0000;
      default: return $urandom;
    endcase
  endfunction

  function automatic idq_pkg::op_e pick_op(input int unsigned push_pct);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 4) return idq_pkg::OP_NOP;
    if ($urandom_range(0, 99) < push_pct) return idq_pkg::OP_PUSH_REAR;
    return $urandom_range(0, 1) ? idq_pkg::OP_POP_FRONT : idq_pkg::OP_POP_REAR;
  endfunction

  task automatic test_corner_cases();
    send_item(idq_pkg::OP_POP_FRONT, 32'h1111_1111);
    send_item(idq_pkg::OP_POP_REAR, 32'h2222_2222);
    send_item(idq_pkg::OP_NOP, 32'h3333_3333);
    send_item(idq_pkg::OP_PUSH_REAR, 32'h8000_0000);
    send_item(idq_pkg::OP_POP_REAR, 32'h0);
    send_item(idq_pkg::OP_PUSH_REAR, 32'h7FFF_FFFF);
    send_item(idq_pkg::OP_POP_FRONT, 32'h0);
    send_item(idq_pkg::OP_PUSH_REAR, 32'h0000_0000);
    send_item(idq_pkg::OP_PUSH_REAR, 32'hFFFF_FFFF);
    send_item(idq_pkg::OP_PUSH_REAR, 32'h8000_0000);
    send_item(idq_pkg::OP_PUSH_REAR, 32'h7FFF_FFFF);
    idle_for(3);
    send_item(idq_pkg::OP_PUSH_REAR, 32'h5555_5555);
    send_item(idq_pkg::OP_PUSH_REAR, 32'hAAAA_AAAA);
    send_item(idq_pkg::OP_PUSH_REAR, 32'h0000_0001);
    send_item(idq_pkg::OP_PUSH_REAR, 32'h1234_5678);
    send_item(idq_pkg::OP_PUSH_REAR, 32'hDEAD_BEEF);
    send_item(idq_pkg::OP_NOP, 32'hFFFF_FFFF);
    send_item(idq_pkg::OP_POP_FRONT, 32'h0);
    send_item(idq_pkg::OP_PUSH_REAR, 32'hCAFE_F00D);
    send_item(idq_pkg::OP_POP_REAR, 32'h0);
    send_item(idq_pkg::OP_POP_REAR, 32'h0);
    send_item(idq_pkg::OP_POP_FRONT, 32'h0);
    send_item(idq_pkg::OP_PUSH_REAR, 32'h0F0F_0F0F);
    wait_drained();
  endtask

  task automatic test_random_traffic(input int unsigned n_items, input bit with_gaps);
    int unsigned  counted;
    int unsigned  push_pct;
    int unsigned  gap_pct;
    idq_pkg::op_e op;
    counted  = 0;
    push_pct = 50;
    gap_pct  = 0;
    while (counted < n_items) begin
      if (counted % 40 == 0) begin
        case ($urandom_range(0, 4))
          0:       push_pct = 90;
          1:       push_pct = 10;
          2:       push_pct = 70;
          3:       push_pct = 30;
          default: push_pct = 50;
        endcase
        gap_pct = with_gaps && $urandom_range(0, 2) != 0 ? $urandom_range(10, 50) : 0;
      end
      op = pick_op(push_pct);
      send_item(op, pick_value());
      if (op != idq_pkg::OP_NOP) counted++;
      if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
        idle_for($urandom_range(1, 12));
      end
    end
  endtask

  task automatic test_pause_until_drained();
    repeat (6) send_item(pick_op(60), pick_value());
    wait_drained();
    repeat (6) send_item(pick_op(40), pick_value());
    wait_drained();
  endtask

  initial begin
    mismatches   = 0;
    stall_cycles = 0;
    head_idx     = 0;
    tail_idx     = 0;
    fill_count   = 0;
    rst_ni      <= 1'b0;
    start       <= 1'b0;
    operation_i <= idq_pkg::OP_NOP;
    value_in_i  <= '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_corner_cases();
    test_random_traffic(700, 1'b1);
    test_pause_until_drained();
    test_random_traffic(500, 1'b1);
    test_random_traffic(400, 1'b0);

    wait_drained();
    repeat (8) @(posedge clk_i);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
design/idq_pkg.sv
design/idq_ctrl.sv
design/idq_dpath.sv
design/input_restricted_deque.sv
design/idq_checker.sv
tb/testbench.sv
